[rtl/core/a1rlp_pkg.sv]
package a1rlp_pkg;

   // Field widths
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned ROW_W    = 24;
   localparam int unsigned COL_W    = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_W    = 24;
   localparam int unsigned CSR_IDX_W = 1;

   // Accumulator widths, one bit of headroom over the index fields
   localparam int unsigned COL_ACC_W = 17;
   localparam int unsigned ROW_ACC_W = 25;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_MANY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COLUMN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ROW    = 1'b1;

   // Register reset values
   localparam logic [COL_W-1:0] MAX_COLUMN_RESET = 16'd16383;
   localparam logic [ROW_W-1:0] MAX_ROW_RESET    = 24'd1048575;

   // Characters of interest
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [CHAR_W-1:0] CHAR_COLON  = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              end_of_text;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]    first_row;
      logic [COL_W-1:0]    first_column;
      logic [ROW_W-1:0]    second_row;
      logic [COL_W-1:0]    second_column;
      logic [STATUS_W-1:0] status;
      logic                last_range;
   } rsp_type;

   // Entry between front and back: one range, plus a flag asking the back
   // end for a trailing empty range after it
   typedef struct packed {
      rsp_type rsp;
      logic    empty_tail;
   } entry_type;

endpackage

[rtl/core/a1_range_list_parser_unit.sv]
// A1 reference list parser. Characters of a reference list such as
// "A1:B7, $C$3,D:F" enter one per cycle on the req_ queue port; one range
// transaction per ',' and one at the end of the text leaves on the rsp_
// queue port, with zero-based corners and a status (0 ok, 1 malformed cell,
// 2 more than two cells, 3 out of range). A character is taken every cycle
// while req_full is low; the parser front end handles it combinationally and pushes
// any range it closes in the same cycle, its multiply-by-26 and multiply-by-10
// accumulators setting that path. Ranges then pass through a QUEUE_DEPTH-entry queue
// to a registered output stage that delivers one result per cycle while rsp_pop
// is high; a ',' on the final character yields two results, the second an empty
// last range. req_full rises only when the queue holds QUEUE_DEPTH ranges not
// yet taken. The user writes the limit registers (csr index 0: largest column,
// index 1: largest row) only while the block is idle; the block does not enforce it.
module a1_range_list_parser_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input characters
   input  logic                             req_push,
   output logic                             req_full,
   input  a1rlp_pkg::req_type               req_data,
   // Ranges
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output a1rlp_pkg::rsp_type               rsp_data,
   // Register writes
   input  logic                             csr_write_enable,
   input  logic [a1rlp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [a1rlp_pkg::CSR_W-1:0]      csr_write_data
);

   logic [a1rlp_pkg::COL_W-1:0] col_limit_ff, col_limit_in;
   logic [a1rlp_pkg::ROW_W-1:0] row_limit_ff, row_limit_in;

   logic                 accept;
   logic                 entry_push;
   a1rlp_pkg::entry_type entry_data;
   a1rlp_pkg::entry_type head_data;
   logic                 head_empty;
   logic                 head_pop;
   logic                 queue_full;

   // Limit registers
   always_comb begin
      col_limit_in = col_limit_ff;
      row_limit_in = row_limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            a1rlp_pkg::CSR_MAX_COLUMN: col_limit_in = csr_write_data[a1rlp_pkg::COL_W-1:0];
            a1rlp_pkg::CSR_MAX_ROW:    row_limit_in = csr_write_data[a1rlp_pkg::ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_limit_ff <= a1rlp_pkg::MAX_COLUMN_RESET;
         row_limit_ff <= a1rlp_pkg::MAX_ROW_RESET;
      end else begin
         col_limit_ff <= col_limit_in;
         row_limit_ff <= row_limit_in;
      end
   end

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   // Parser front end
   a1rlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .col_limit  (col_limit_ff),
      .row_limit  (row_limit_ff),
      .entry_push (entry_push),
      .entry_data (entry_data)
   );

   // Range queue
   a1rlp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (entry_push),
      .push_data (entry_data),
      .pop       (head_pop),
      .head_data (head_data),
      .full      (queue_full),
      .empty     (head_empty)
   );

   // Result delivery
   a1rlp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (head_data),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .col_limit  (col_limit_ff),
      .row_limit  (row_limit_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/core/a1rlp_front.sv]
module a1rlp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  a1rlp_pkg::req_type                req_data,
   input  logic [a1rlp_pkg::COL_W-1:0]       col_limit,
   input  logic [a1rlp_pkg::ROW_W-1:0]       row_limit,
   output logic                              entry_push,
   output a1rlp_pkg::entry_type              entry_data
);

   typedef enum logic [2:0] {
      CLS_SKIP,
      CLS_LETTER,
      CLS_DIGIT,
      CLS_COLON,
      CLS_COMMA,
      CLS_OTHER
   } char_class_type;

   localparam logic [a1rlp_pkg::COL_ACC_W-1:0] COL_ACC_SAT = '1;
   localparam logic [a1rlp_pkg::ROW_ACC_W-1:0] ROW_ACC_SAT = '1;

   // Parser state
   logic [a1rlp_pkg::COL_ACC_W-1:0] col_acc_ff, col_acc_in;
   logic [a1rlp_pkg::ROW_ACC_W-1:0] row_acc_ff, row_acc_in;
   logic                            seen_letters_ff, seen_letters_in;
   logic                            seen_digits_ff, seen_digits_in;
   logic [1:0]                      cell_count_ff, cell_count_in;
   logic [a1rlp_pkg::ROW_W-1:0]     saved_row_ff, saved_row_in;
   logic [a1rlp_pkg::COL_W-1:0]     saved_col_ff, saved_col_in;
   logic [a1rlp_pkg::STATUS_W-1:0]  err_ff, err_in;

   char_class_type                  char_class;
   logic [a1rlp_pkg::CHAR_W-1:0]    ch;

   // State after the character's own effect
   logic [a1rlp_pkg::COL_ACC_W-1:0] col_acc_a;
   logic [a1rlp_pkg::ROW_ACC_W-1:0] row_acc_a;
   logic                            seen_letters_a, seen_digits_a;
   logic [a1rlp_pkg::STATUS_W-1:0]  err_a;
   logic [22:0]                     col_prod;
   logic [29:0]                     row_prod;

   // Corner close
   logic [a1rlp_pkg::COL_ACC_W-1:0] col_dec;
   logic [a1rlp_pkg::ROW_ACC_W-1:0] row_dec;
   logic                            col_over, row_zero, row_over;
   logic [a1rlp_pkg::COL_W-1:0]     close_col;
   logic [a1rlp_pkg::ROW_W-1:0]     close_row;
   logic [a1rlp_pkg::STATUS_W-1:0]  err_c, err_colon;

   // Colon outcome
   logic [1:0]                      cell_post;
   logic [a1rlp_pkg::ROW_W-1:0]     saved_row_post;
   logic [a1rlp_pkg::COL_W-1:0]     saved_col_post;

   logic                            is_colon, is_comma, emit;

   assign ch = req_data.character;

   // Character classification
   always_comb begin
      priority if (ch == a1rlp_pkg::CHAR_SPACE || ch == a1rlp_pkg::CHAR_DOLLAR) begin
         char_class = CLS_SKIP;
      end else if ((ch >= a1rlp_pkg::CHAR_UPPER_A && ch <= a1rlp_pkg::CHAR_UPPER_Z) ||
                   (ch >= a1rlp_pkg::CHAR_LOWER_A && ch <= a1rlp_pkg::CHAR_LOWER_Z)) begin
         char_class = CLS_LETTER;
      end else if (ch >= a1rlp_pkg::CHAR_ZERO && ch <= a1rlp_pkg::CHAR_NINE) begin
         char_class = CLS_DIGIT;
      end else if (ch == a1rlp_pkg::CHAR_COLON) begin
         char_class = CLS_COLON;
      end else if (ch == a1rlp_pkg::CHAR_COMMA) begin
         char_class = CLS_COMMA;
      end else begin
         char_class = CLS_OTHER;
      end
   end

   assign is_colon = (char_class == CLS_COLON);
   assign is_comma = (char_class == CLS_COMMA);

   // Accumulate; letter value is the low five bits for either case
   assign col_prod = 23'(col_acc_ff) * 23'd26 + 23'(ch[4:0]);
   assign row_prod = 30'(row_acc_ff) * 30'd10 + 30'(ch[3:0]);

   always_comb begin
      col_acc_a      = col_acc_ff;
      row_acc_a      = row_acc_ff;
      seen_letters_a = seen_letters_ff;
      seen_digits_a  = seen_digits_ff;
      err_a          = err_ff;
      unique case (char_class)
         CLS_LETTER: begin
            if (seen_digits_ff) begin
               if (err_ff == a1rlp_pkg::STATUS_OK) err_a = a1rlp_pkg::STATUS_MALFORMED;
            end else begin
               col_acc_a = (col_prod > 23'(COL_ACC_SAT)) ? COL_ACC_SAT
                                                         : col_prod[a1rlp_pkg::COL_ACC_W-1:0];
               seen_letters_a = 1'b1;
            end
         end
         CLS_DIGIT: begin
            row_acc_a = (row_prod > 30'(ROW_ACC_SAT)) ? ROW_ACC_SAT
                                                      : row_prod[a1rlp_pkg::ROW_ACC_W-1:0];
            seen_digits_a = 1'b1;
         end
         CLS_OTHER: begin
            if (err_ff == a1rlp_pkg::STATUS_OK) err_a = a1rlp_pkg::STATUS_MALFORMED;
         end
         default: begin
         end
      endcase
   end

   // Close the corner held in the accumulators
   assign col_dec  = (col_acc_a == '0) ? '0 : col_acc_a - 1'b1;
   assign row_dec  = row_acc_a - 1'b1;
   assign col_over = seen_letters_a && (col_dec > {1'b0, col_limit});
   assign row_zero = seen_digits_a && (row_acc_a == '0);
   assign row_over = seen_digits_a && !row_zero && (row_dec > {1'b0, row_limit});

   always_comb begin
      if (!seen_letters_a || col_over) close_col = col_limit;
      else                             close_col = col_dec[a1rlp_pkg::COL_W-1:0];

      if (!seen_digits_a || row_over) close_row = row_limit;
      else if (row_zero)              close_row = '0;
      else                            close_row = row_dec[a1rlp_pkg::ROW_W-1:0];

      // First error found wins: column range, then row zero, then row range
      priority if (err_a != a1rlp_pkg::STATUS_OK) err_c = err_a;
      else if (col_over)                          err_c = a1rlp_pkg::STATUS_RANGE;
      else if (row_zero)                          err_c = a1rlp_pkg::STATUS_MALFORMED;
      else if (row_over)                          err_c = a1rlp_pkg::STATUS_RANGE;
      else                                        err_c = a1rlp_pkg::STATUS_OK;
   end

   // Colon: first corner saved, or a third cell flagged
   always_comb begin
      cell_post      = cell_count_ff;
      saved_row_post = saved_row_ff;
      saved_col_post = saved_col_ff;
      err_colon      = err_c;
      if (is_colon) begin
         if (cell_count_ff == 2'd0) begin
            saved_row_post = close_row;
            saved_col_post = close_col;
            cell_post      = 2'd1;
         end else begin
            if (err_c == a1rlp_pkg::STATUS_OK) err_colon = a1rlp_pkg::STATUS_TOO_MANY;
            cell_post = 2'd2;
         end
      end
   end

   // Range emission at a comma or at the end of the text
   assign emit = accept && (is_comma || req_data.end_of_text);

   always_comb begin
      entry_data = '0;
      if (cell_post == 2'd0) begin
         entry_data.rsp.first_row    = close_row;
         entry_data.rsp.first_column = close_col;
      end else begin
         entry_data.rsp.first_row    = saved_row_post;
         entry_data.rsp.first_column = saved_col_post;
      end
      // After a colon the open corner is empty
      if (is_colon) begin
         entry_data.rsp.second_row    = row_limit;
         entry_data.rsp.second_column = col_limit;
      end else begin
         entry_data.rsp.second_row    = close_row;
         entry_data.rsp.second_column = close_col;
      end
      entry_data.rsp.status     = err_colon;
      entry_data.rsp.last_range = req_data.end_of_text && !is_comma;
      entry_data.empty_tail     = req_data.end_of_text && is_comma;
   end

   assign entry_push = emit;

   // Next state
   always_comb begin
      col_acc_in      = col_acc_ff;
      row_acc_in      = row_acc_ff;
      seen_letters_in = seen_letters_ff;
      seen_digits_in  = seen_digits_ff;
      cell_count_in   = cell_count_ff;
      saved_row_in    = saved_row_ff;
      saved_col_in    = saved_col_ff;
      err_in          = err_ff;
      if (accept) begin
         saved_row_in = saved_row_post;
         saved_col_in = saved_col_post;
         if (emit) begin
            col_acc_in      = '0;
            row_acc_in      = '0;
            seen_letters_in = 1'b0;
            seen_digits_in  = 1'b0;
            cell_count_in   = 2'd0;
            err_in          = a1rlp_pkg::STATUS_OK;
         end else if (is_colon) begin
            col_acc_in      = '0;
            row_acc_in      = '0;
            seen_letters_in = 1'b0;
            seen_digits_in  = 1'b0;
            cell_count_in   = cell_post;
            err_in          = err_colon;
         end else begin
            col_acc_in      = col_acc_a;
            row_acc_in      = row_acc_a;
            seen_letters_in = seen_letters_a;
            seen_digits_in  = seen_digits_a;
            err_in          = err_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_acc_ff      <= '0;
         row_acc_ff      <= '0;
         seen_letters_ff <= 1'b0;
         seen_digits_ff  <= 1'b0;
         cell_count_ff   <= 2'd0;
         saved_row_ff    <= '0;
         saved_col_ff    <= '0;
         err_ff          <= a1rlp_pkg::STATUS_OK;
      end else begin
         col_acc_ff      <= col_acc_in;
         row_acc_ff      <= row_acc_in;
         seen_letters_ff <= seen_letters_in;
         seen_digits_ff  <= seen_digits_in;
         cell_count_ff   <= cell_count_in;
         saved_row_ff    <= saved_row_in;
         saved_col_ff    <= saved_col_in;
         err_ff          <= err_in;
      end
   end

endmodule

[rtl/core/a1rlp_queue.sv]
module a1rlp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  a1rlp_pkg::entry_type  push_data,
   input  logic                  pop,
   output a1rlp_pkg::entry_type  head_data,
   output logic                  full,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   a1rlp_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entries_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[rtl/core/a1rlp_back.sv]
module a1rlp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  a1rlp_pkg::entry_type         head_data,
   input  logic                         head_empty,
   output logic                         head_pop,
   input  logic [a1rlp_pkg::COL_W-1:0]  col_limit,
   input  logic [a1rlp_pkg::ROW_W-1:0]  row_limit,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output a1rlp_pkg::rsp_type           rsp_data
);

   logic               out_valid_ff, out_valid_in;
   a1rlp_pkg::rsp_type out_data_ff, out_data_in;
   logic               tail_pend_ff, tail_pend_in;
   logic               load;
   a1rlp_pkg::rsp_type tail_rsp;

   // Empty final range after a comma on the last character
   always_comb begin
      tail_rsp               = '0;
      tail_rsp.first_row     = row_limit;
      tail_rsp.first_column  = col_limit;
      tail_rsp.second_row    = row_limit;
      tail_rsp.second_column = col_limit;
      tail_rsp.status        = a1rlp_pkg::STATUS_OK;
      tail_rsp.last_range    = 1'b1;
   end

   // Output register refills whenever it is free or being taken
   assign load     = !out_valid_ff || rsp_pop;
   assign head_pop = load && !tail_pend_ff && !head_empty;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      tail_pend_in = tail_pend_ff;
      if (load) begin
         if (tail_pend_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = tail_rsp;
            tail_pend_in = 1'b0;
         end else if (!head_empty) begin
            out_valid_in = 1'b1;
            out_data_in  = head_data.rsp;
            tail_pend_in = head_data.empty_tail;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         tail_pend_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         tail_pend_ff <= tail_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[tb/a1_range_list_parser_unit_tb.sv]
import a1rlp_pkg::*;

// Tracks the parser state from the characters taken in and keeps the ranges
// the block still owes, oldest first.
class range_scoreboard;
   localparam longint unsigned COL_SAT = (64'd1 << COL_ACC_W) - 1;
   localparam longint unsigned ROW_SAT = (64'd1 << ROW_ACC_W) - 1;

   logic [COL_W-1:0]     col_limit;
   logic [ROW_W-1:0]     row_limit;
   logic [COL_ACC_W-1:0] col_acc;
   logic [ROW_ACC_W-1:0] row_acc;
   bit                   seen_letters;
   bit                   seen_digits;
   logic [1:0]           cell_count;
   logic [ROW_W-1:0]     held_row;
   logic [COL_W-1:0]     held_col;
   logic [STATUS_W-1:0]  range_status;
   rsp_type              expected_ranges[$];
   int unsigned          mismatches;

   function new();
      col_limit    = MAX_COLUMN_RESET;
      row_limit    = MAX_ROW_RESET;
      col_acc      = '0;
      row_acc      = '0;
      seen_letters = 1'b0;
      seen_digits  = 1'b0;
      cell_count   = '0;
      held_row     = '0;
      held_col     = '0;
      range_status = STATUS_OK;
      mismatches   = 0;
   endfunction

   function int unsigned pending();
      return expected_ranges.size();
   endfunction

   // Register write, masked to the register width
   function void write_limit(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      if (idx == CSR_MAX_COLUMN) begin
         col_limit = data[COL_W-1:0];
      end else if (idx == CSR_MAX_ROW) begin
         row_limit = data[ROW_W-1:0];
      end
   endfunction

   // First error of a range wins
   function void flag(logic [STATUS_W-1:0] code);
      if (range_status == STATUS_OK) range_status = code;
   endfunction

   // Finish the corner being built and clear the accumulators
   function void close_corner(output logic [ROW_W-1:0] row, output logic [COL_W-1:0] col);
      int unsigned c;
      int unsigned r;
      if (seen_letters) begin
         c = col_acc;
         if (c != 0) c = c - 1;
         if (c > col_limit) begin
            flag(STATUS_RANGE);
            c = col_limit;
         end
      end else begin
         c = col_limit;
      end
      if (seen_digits) begin
         if (row_acc == 0) begin
            flag(STATUS_MALFORMED);
            r = 0;
         end else begin
            r = row_acc - 1;
            if (r > row_limit) begin
               flag(STATUS_RANGE);
               r = row_limit;
            end
         end
      end else begin
         r = row_limit;
      end
      col_acc      = '0;
      row_acc      = '0;
      seen_letters = 1'b0;
      seen_digits  = 1'b0;
      row = r[ROW_W-1:0];
      col = c[COL_W-1:0];
   endfunction

   function void emit_range(bit last);
      rsp_type          want;
      logic [ROW_W-1:0] r;
      logic [COL_W-1:0] c;
      close_corner(r, c);
      if (cell_count == 0) begin
         want.first_row    = r;
         want.first_column = c;
      end else begin
         want.first_row    = held_row;
         want.first_column = held_col;
      end
      want.second_row    = r;
      want.second_column = c;
      want.status        = range_status;
      want.last_range    = last;
      expected_ranges.insert(expected_ranges.size(), want);
      cell_count   = '0;
      range_status = STATUS_OK;
   endfunction

   // One accepted character transaction
   function void note_character(req_type item);
      logic [CHAR_W-1:0] ch;
      longint unsigned   acc;
      int unsigned       v;
      logic [ROW_W-1:0]  r;
      logic [COL_W-1:0]  c;
      ch = item.character;
      if (ch == CHAR_SPACE || ch == CHAR_DOLLAR) begin
         // skipped
      end else if ((ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ||
                   (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)) begin
         if (seen_digits) begin
            flag(STATUS_MALFORMED);
         end else begin
            v = (ch < CHAR_LOWER_A) ? ch - CHAR_UPPER_A + 1 : ch - CHAR_LOWER_A + 1;
            acc = 64'(col_acc) * 26 + v;
            col_acc = (acc > COL_SAT) ? COL_SAT[COL_ACC_W-1:0] : acc[COL_ACC_W-1:0];
            seen_letters = 1'b1;
         end
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         acc = 64'(row_acc) * 10 + (ch - CHAR_ZERO);
         row_acc = (acc > ROW_SAT) ? ROW_SAT[ROW_ACC_W-1:0] : acc[ROW_ACC_W-1:0];
         seen_digits = 1'b1;
      end else if (ch == CHAR_COLON) begin
         close_corner(r, c);
         if (cell_count == 0) begin
            held_row   = r;
            held_col   = c;
            cell_count = 2'd1;
         end else begin
            flag(STATUS_TOO_MANY);
            cell_count = 2'd2;
         end
      end else if (ch == CHAR_COMMA) begin
         emit_range(1'b0);
      end else begin
         flag(STATUS_MALFORMED);
      end
      if (item.end_of_text) emit_range(1'b1);
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // One accepted range transaction against the oldest expectation
   function void check_range(rsp_type got);
      rsp_type want;
      if (expected_ranges.size() == 0) begin
         $display("%0t: range with none expected, expected nothing, actual %h", $time, got);
         mismatches++;
         return;
      end
      want = expected_ranges.pop_front();
      compare_field("first_row", 32'(want.first_row), 32'(got.first_row));
      compare_field("first_column", 32'(want.first_column), 32'(got.first_column));
      compare_field("second_row", 32'(want.second_row), 32'(got.second_row));
      compare_field("second_column", 32'(want.second_column), 32'(got.second_column));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("last_range", 32'(want.last_range), 32'(got.last_range));
   endfunction
endclass

module a1_range_list_parser_unit_tb;

   localparam int unsigned CYCLE_LIMIT      = 250000;
   localparam int unsigned SETTLE_CYCLES    = 16;
   localparam int unsigned RANDOM_PER_PHASE = 390;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_push         = 1'b0;
   logic                 req_full;
   req_type              req_data         = '0;
   logic                 rsp_empty;
   logic                 rsp_pop          = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [CSR_W-1:0]     csr_write_data   = '0;

   range_scoreboard   ranges;
   int unsigned       push_gap_pct  = 0;
   int unsigned       pop_stall_pct = 0;
   int unsigned       chars_sent    = 0;
   logic [CHAR_W-1:0] text_buf[$];

   a1_range_list_parser_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Transactions are taken at the rising edge on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) ranges.note_character(req_data);
         if (rsp_pop && !rsp_empty) ranges.check_range(rsp_data);
      end
   end

   // Receiver: pops by default, stalls in bursts
   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) < pop_stall_pct) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_pop <= 1'b1;
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
      req_type item;
      item.character   = ch;
      item.end_of_text = last;
      req_data <= item;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic hold_sender(input int unsigned cycles);
      req_push <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_buf[i]) begin
         push_char(text_buf[i], i == text_buf.size() - 1);
         if ($urandom_range(0, 99) < push_gap_pct) hold_sender($urandom_range(1, 9));
      end
   endtask

   // Sender stops until every range is out, then the pipe settles
   task automatic wait_idle();
      hold_sender(1);
      while (ranges.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Both limit registers, back to back; junk above the column width
   task automatic set_limits(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      logic [CSR_W-COL_W-1:0] junk;
      junk = (CSR_W-COL_W)'($urandom);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MAX_COLUMN;
      csr_write_data   <= {junk, col};
      ranges.write_limit(CSR_MAX_COLUMN, {junk, col});
      @(negedge clock);
      csr_index      <= CSR_MAX_ROW;
      csr_write_data <= row;
      ranges.write_limit(CSR_MAX_ROW, row);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic void append_char(logic [CHAR_W-1:0] ch);
      text_buf.insert(text_buf.size(), ch);
   endfunction

   function automatic void add_string(string s);
      foreach (s[i]) append_char(s[i]);
   endfunction

   function automatic logic [CHAR_W-1:0] rand_letter();
      logic [CHAR_W-1:0] base;
      base = $urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A;
      return base + CHAR_W'($urandom_range(0, 25));
   endfunction

   // One cell: optional '$', letters, optional '$', digits, odd faults
   function automatic void add_cell();
      int unsigned pick;
      int unsigned n_letters;
      int unsigned n_digits;
      if ($urandom_range(0, 2) == 0) append_char(CHAR_DOLLAR);
      pick = $urandom_range(0, 99);
      n_letters = (pick < 15) ? 0 : (pick < 75) ? $urandom_range(1, 2) :
                  (pick < 90) ? 3 : $urandom_range(4, 5);
      repeat (n_letters) append_char(rand_letter());
      if ($urandom_range(0, 2) == 0) append_char(CHAR_DOLLAR);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         // row zero
         append_char(CHAR_ZERO);
      end else begin
         n_digits = (pick < 20) ? 0 : (pick < 75) ? $urandom_range(1, 4) :
                    (pick < 92) ? $urandom_range(5, 7) : $urandom_range(8, 9);
         repeat (n_digits) append_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
      end
      // letter after digits
      if ($urandom_range(0, 19) == 0) append_char(rand_letter());
      if ($urandom_range(0, 9) == 0) append_char(CHAR_SPACE);
   endfunction

   // A reference list, mostly well formed, now and then with stray bytes
   function automatic void build_text();
      int unsigned       n_ranges;
      int unsigned       n_cells;
      int unsigned       pick;
      int unsigned       r;
      int unsigned       c;
      logic [CHAR_W-1:0] noise;
      text_buf.delete();
      n_ranges = $urandom_range(1, 4);
      for (r = 0; r < n_ranges; r++) begin
         if (r != 0) append_char(CHAR_COMMA);
         pick = $urandom_range(0, 99);
         n_cells = (pick < 8) ? 0 : (pick < 50) ? 1 : (pick < 90) ? 2 : $urandom_range(3, 4);
         for (c = 0; c < n_cells; c++) begin
            if (c != 0) append_char(CHAR_COLON);
            add_cell();
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // run of empty ranges to back the result queue up
         repeat ($urandom_range(2, 10)) append_char(CHAR_COMMA);
      end else if (pick < 16) begin
         append_char(CHAR_COMMA);
      end
      if (text_buf.size() == 0) append_char(CHAR_SPACE);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            noise = CHAR_W'($urandom);
            text_buf.insert($urandom_range(0, text_buf.size() - 1), noise);
         end
      end
   endfunction

   task automatic run_random(input int unsigned quota, input bit quiet);
      int unsigned stop_at;
      stop_at = chars_sent + quota;
      while (chars_sent < stop_at) begin
         push_gap_pct  = quiet ? 0 : 10 * $urandom_range(0, 3);
         pop_stall_pct = quiet ? 0 : 10 * $urandom_range(0, 3);
         build_text();
         send_text();
      end
   endtask

   initial begin
      ranges = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: row zero, letters after digits, stray bytes, third cell,
      // empty range and cell, separator on the final character
      push_gap_pct  = 20;
      pop_stall_pct = 20;
      text_buf.delete();
      add_string("A0:1b,");
      append_char(8'h00);
      add_string("B2:C3:D4,");
      append_char(8'hFF);
      add_string(",:,$ 7,");
      send_text();
      run_random(RANDOM_PER_PHASE, 1'b0);

      // Limits at zero: almost every corner overflows
      wait_idle();
      set_limits('0, '0);
      run_random(RANDOM_PER_PHASE, 1'b0);

      // Limits at full width: accumulator saturation shows through
      wait_idle();
      set_limits('1, '1);
      run_random(RANDOM_PER_PHASE, 1'b0);

      wait_idle();
      set_limits(COL_W'($urandom_range(0, 40)), ROW_W'($urandom_range(0, 150)));
      run_random(RANDOM_PER_PHASE, 1'b0);

      // Last part flat out on both sides
      wait_idle();
      set_limits(COL_W'($urandom), ROW_W'($urandom));
      run_random(RANDOM_PER_PHASE, 1'b1);

      wait_idle();
      if (ranges.mismatches == 0 && ranges.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/a1rlp_pkg.sv
rtl/core/a1rlp_front.sv
rtl/core/a1rlp_queue.sv
rtl/core/a1rlp_back.sv
rtl/core/a1_range_list_parser_unit.sv
tb/a1_range_list_parser_unit_tb.sv
